// ===== rtl/core/tbr_pkg.sv =====
// Shared types and constants for the triangle bounding-box rasterizer.
// No dependencies.
`timescale 1ns / 1ps

package tbr_pkg;

    typedef struct packed {
        logic              mode;
        logic signed [11:0] ax;
        logic signed [11:0] ay;
        logic signed [11:0] bx;
        logic signed [11:0] by_coord;
        logic signed [11:0] cx;
        logic signed [11:0] cy;
        logic [11:0]       origin_x;
        logic [11:0]       origin_y;
        logic [10:0]       tex_width;
        logic [10:0]       tex_height;
    } t_in_beat;

    typedef struct packed {
        logic        covered;
        logic        on_screen;
        logic [11:0] screen_x;
        logic [11:0] screen_y;
        logic [7:0]  tile_x;
        logic [7:0]  tile_y;
        logic [7:0]  offset_x;
        logic [7:0]  offset_y;
        logic [20:0] texel_index;
        logic        last;
        logic        done_res;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_DIV_U,
        ST_DIV_V,
        ST_FINISH,
        ST_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // latch a new triangle
        logic empty;     // build a done result
        logic edge_calc; // register the edge test result
        logic div_start; // begin one division
        logic div_sel_v; // 0: u division, 1: v division
        logic finish;    // assemble result and advance walk
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic active;
        logic div_busy;
    } t_status;

    localparam int DIV_BITS = 23;
    localparam int MODE_LOAD = 0;

endpackage

// ===== rtl/core/triangle_bbox_rasterizer.sv =====
// A load gives no result. A step on an active box latches its edge products and starts
// the serial u division on acceptance, then runs the edge test, the serial v division
// and assembly; an idle step gives its result in the cycle after acceptance. One item
// at a time: a step holds off the input until its result has been taken.
// Synchronous active-low reset clears the walk; texture size resets to 1.
// Depends on tbr_pkg, tbr_ctrl, tbr_dp.
`timescale 1ns / 1ps

module triangle_bbox_rasterizer #(
    parameter int TILE_SHIFT = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tbr_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output tbr_pkg::t_out_beat o_data
);
    import tbr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tbr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_data.mode),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    tbr_dp #(.TILE_SHIFT(TILE_SHIFT)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_data   (o_data)
    );

endmodule

// ===== rtl/core/tbr_ctrl.sv =====
// Controller state machine for the rasterizer.
// Depends on tbr_pkg.
`timescale 1ns / 1ps

module tbr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_mode,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  tbr_pkg::t_status i_status,
    output tbr_pkg::t_cmd   o_cmd
);
    import tbr_pkg::*;

    t_state r_state, n_state;
    logic   w_acc;

    // Take a beat only while idle.
    assign w_acc = i_valid && (r_state == ST_IDLE);

    // Register state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && i_mode) begin
                    n_state = i_status.active ? ST_EDGE : ST_OUT;
                end
            end
            ST_EDGE:  n_state = ST_DIV_U;
            ST_DIV_U: if (!i_status.div_busy) n_state = ST_DIV_V;
            ST_DIV_V: if (!i_status.div_busy) n_state = ST_FINISH;
            ST_FINISH: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.load    = w_acc && !i_mode;
                o_cmd.empty   = w_acc && i_mode && !i_status.active;
                o_cmd.div_start = w_acc && i_mode && i_status.active;
            end
            ST_EDGE: begin
                o_cmd.edge_calc = 1'b1;
            end
            ST_DIV_U: begin
                o_cmd.div_start = !i_status.div_busy;
                o_cmd.div_sel_v = 1'b1;
            end
            ST_DIV_V: begin
                o_cmd.div_sel_v = 1'b1;
            end
            ST_FINISH: o_cmd.finish = 1'b1;
            ST_OUT:    o_valid = 1'b1;
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_valid)
        else $error("load produced a result");
`endif

endmodule

// ===== rtl/core/tbr_dp.sv =====
// Datapath: triangle registers, edge test, shared serial divider, walk.
// Depends on tbr_pkg.
`timescale 1ns / 1ps

module tbr_dp #(
    parameter int TILE_SHIFT = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tbr_pkg::t_in_beat i_data,
    input  tbr_pkg::t_cmd     i_cmd,
    output tbr_pkg::t_status  o_status,
    output tbr_pkg::t_out_beat o_data
);
    import tbr_pkg::*;

    localparam int CW = $clog2(DIV_BITS + 1);

    logic signed [11:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [11:0] r_ox, r_oy;
    logic [10:0] r_tw, r_th;
    logic signed [11:0] r_xmin, r_xmax, r_ymin, r_ymax;
    logic signed [11:0] r_wx, r_wy;
    logic r_active;

    // Vertex min and max.
    function automatic logic signed [11:0] f_min3(input logic signed [11:0] a,
        input logic signed [11:0] b, input logic signed [11:0] c);
        logic signed [11:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction
    function automatic logic signed [11:0] f_max3(input logic signed [11:0] a,
        input logic signed [11:0] b, input logic signed [11:0] c);
        logic signed [11:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic signed [11:0] w_xmin, w_xmax, w_ymin, w_ymax;
    assign w_xmin = f_min3(i_data.ax, i_data.bx, i_data.cx);
    assign w_xmax = f_max3(i_data.ax, i_data.bx, i_data.cx);
    assign w_ymin = f_min3(i_data.ay, i_data.by_coord, i_data.cy);
    assign w_ymax = f_max3(i_data.ay, i_data.by_coord, i_data.cy);

    // Next walk position.
    logic signed [12:0] w_nx, w_ny;
    logic w_row_end, w_box_end;
    assign w_nx = {r_wx[11], r_wx} + 13'sd1;
    assign w_ny = {r_wy[11], r_wy} + 13'sd1;
    assign w_row_end = w_nx >= $signed({r_xmax[11], r_xmax});
    assign w_box_end = w_row_end && (w_ny >= $signed({r_ymax[11], r_ymax}));

    // Triangle and walk registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0; r_ay <= '0; r_bx <= '0; r_by <= '0; r_cx <= '0; r_cy <= '0;
            r_ox <= '0; r_oy <= '0; r_tw <= 11'd1; r_th <= 11'd1;
            r_xmin <= '0; r_xmax <= '0; r_ymin <= '0; r_ymax <= '0;
            r_wx <= '0; r_wy <= '0; r_active <= 1'b0;
        end else if (i_cmd.load) begin
            r_ax <= i_data.ax; r_ay <= i_data.ay;
            r_bx <= i_data.bx; r_by <= i_data.by_coord;
            r_cx <= i_data.cx; r_cy <= i_data.cy;
            r_ox <= i_data.origin_x; r_oy <= i_data.origin_y;
            r_tw <= i_data.tex_width; r_th <= i_data.tex_height;
            r_xmin <= w_xmin; r_xmax <= w_xmax;
            r_ymin <= w_ymin; r_ymax <= w_ymax;
            r_wx <= w_xmin; r_wy <= w_ymin;
            r_active <= (w_xmin < w_xmax) && (w_ymin < w_ymax);
        end else if (i_cmd.finish) begin
            if (w_row_end) begin
                r_wx <= r_xmin;
                r_wy <= w_ny[11:0];
                if (w_box_end) r_active <= 1'b0;
            end else begin
                r_wx <= w_nx[11:0];
            end
        end
    end

    // Edge functions: differences fit 14 bits, products 28, sums 29 bits.
    logic signed [13:0] w_px, w_py, w_fx, w_fy, w_ex, w_ey, w_gx, w_gy, w_hx, w_hy;
    assign w_px = 14'(r_wx) - 14'(r_ax);
    assign w_py = 14'(r_wy) - 14'(r_ay);
    assign w_fx = 14'(r_cx) - 14'(r_ax);
    assign w_fy = 14'(r_cy) - 14'(r_ay);
    assign w_ex = 14'(r_ax) - 14'(r_bx);
    assign w_ey = 14'(r_ay) - 14'(r_by);
    assign w_gx = 14'(r_cx) - 14'(r_bx);
    assign w_gy = 14'(r_cy) - 14'(r_by);
    assign w_hx = w_fx - w_px;
    assign w_hy = w_fy - w_py;

    logic signed [28:0] r_k0, r_k1, r_k2;
    logic r_cov;
    logic w_s0, w_s1, w_s2, w_z0, w_z1, w_z2;
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start && !i_cmd.div_sel_v) begin
            r_k0 <= 29'(w_px * w_fy) - 29'(w_fx * w_py);
            r_k1 <= 29'(w_px * w_ey) - 29'(w_ex * w_py);
            r_k2 <= 29'(w_hx * w_gy) - 29'(w_gx * w_hy);
        end
    end
    assign w_s0 = r_k0[28]; assign w_z0 = (r_k0 == '0);
    assign w_s1 = r_k1[28]; assign w_z1 = (r_k1 == '0);
    assign w_s2 = r_k2[28]; assign w_z2 = (r_k2 == '0);
    // Product >= 0 when either is zero or signs match.
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_calc) begin
            r_cov <= (w_z0 || w_z1 || w_s0 == w_s1) &&
                     (w_z1 || w_z2 || w_s1 == w_s2) &&
                     (w_z0 || w_z2 || w_s0 == w_s2);
        end
    end

    // Division operands: numerator (max-pos)*dim, denominator box extent.
    logic [12:0] w_du, w_dv, w_wb, w_hb;
    assign w_du = 13'(r_xmax) - 13'(r_wx);
    assign w_dv = 13'(r_ymax) - 13'(r_wy);
    assign w_wb = 13'(r_xmax) - 13'(r_xmin);
    assign w_hb = 13'(r_ymax) - 13'(r_ymin);

    logic [DIV_BITS-1:0] r_quo, r_u;
    logic [13:0] r_rem;
    logic [12:0] r_den;
    logic [CW-1:0] r_cnt;
    logic r_busy;
    logic [13:0] w_trial;
    logic [14:0] w_sub;

    assign w_trial = {r_rem[12:0], r_quo[DIV_BITS-1]};
    assign w_sub = {1'b0, w_trial} - {2'b0, r_den};

    // Restoring divider, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DIV_BITS);
            r_rem  <= '0;
            if (i_cmd.div_sel_v) begin
                r_u   <= r_quo;
                r_quo <= DIV_BITS'(w_dv * r_th);
                r_den <= w_hb;
            end else begin
                r_quo <= DIV_BITS'(w_du * r_tw);
                r_den <= w_wb;
            end
        end else if (r_busy) begin
            if (!w_sub[14]) begin
                r_rem <= w_sub[13:0];
                r_quo <= {r_quo[DIV_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[DIV_BITS-2:0], 1'b0};
            end
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    assign o_status.active   = r_active;
    assign o_status.div_busy = r_busy;

    // Screen position and texel products.
    logic signed [12:0] w_sx, w_sy;
    logic w_on;
    assign w_sx = $signed({1'b0, r_ox}) - 13'(r_wx);
    assign w_sy = $signed({1'b0, r_oy}) - 13'(r_wy);
    assign w_on = !w_sx[12] && !w_sy[12];

    logic [11:0] w_ux, w_uy;
    assign w_ux = w_sx[11:0];
    assign w_uy = w_sy[11:0];

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.empty) begin
            o_data <= t_out_beat'{done_res: 1'b1, default: '0};
        end else if (i_cmd.finish) begin
            o_data.covered   <= r_cov;
            o_data.on_screen <= w_on;
            o_data.screen_x  <= w_on ? w_ux : '0;
            o_data.screen_y  <= w_on ? w_uy : '0;
            o_data.tile_x    <= w_on ? 8'(w_ux >> TILE_SHIFT) : '0;
            o_data.tile_y    <= w_on ? 8'(w_uy >> TILE_SHIFT) : '0;
            o_data.offset_x  <= w_on ? 8'(w_ux & 12'((1 << TILE_SHIFT) - 1)) : '0;
            o_data.offset_y  <= w_on ? 8'(w_uy & 12'((1 << TILE_SHIFT) - 1)) : '0;
            o_data.texel_index <= 21'(r_u + DIV_BITS'(34'(r_quo) * 34'(r_tw)));
            o_data.last      <= w_box_end;
            o_data.done_res  <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start && i_cmd.div_sel_v |-> !r_busy)
        else $error("divider restarted while busy");
    a_walk_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_wx >= r_xmin && r_wx < r_xmax && r_wy >= r_ymin && r_wy < r_ymax))
        else $error("walk left the box");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && w_box_end) |=> !r_active)
        else $error("walk continued past last pixel");
`endif

endmodule

// ===== bench/triangle_bbox_rasterizer_checker.sv =====
// Checker for the triangle bounding-box rasterizer: watches both channels,
// predicts each result beat and compares it as a whole beat. Depends on tbr_pkg.
`timescale 1ns / 1ps

module triangle_bbox_rasterizer_checker #(
    parameter int TILE_SHIFT = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    input  tbr_pkg::t_in_beat  i_data,
    input  logic               o_valid,
    input  logic               o_stall,
    input  tbr_pkg::t_out_beat o_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_pixels,
    output int                 o_covered
);
    import tbr_pkg::*;

    // Shadow state of the rasterizer
    longint vtx [6];
    longint org_x, org_y;
    longint tex_w, tex_h;
    longint bx_min, bx_max, by_min, by_max;
    longint walk_px, walk_py;
    bit     walking;

    t_out_beat pixel_queue[$];

    function automatic bit edge_test(longint x, longint y);
        longint px, py, fx, fy, k0, k1, k2;
        px = x - vtx[0];
        py = y - vtx[1];
        fx = vtx[4] - vtx[0];
        fy = vtx[5] - vtx[1];
        k0 = px * fy - fx * py;
        k1 = px * (vtx[1] - vtx[3]) - (vtx[0] - vtx[2]) * py;
        k2 = (fx - px) * (vtx[5] - vtx[3]) - (vtx[4] - vtx[2]) * (fy - py);
        return (k0 * k1 >= 0) && (k1 * k2 >= 0) && (k0 * k2 >= 0);
    endfunction

    task automatic rasterize_beat(t_in_beat b);
        t_out_beat r;
        longint sx, sy, u, v, texel;
        bit on;
        if (b.mode == 1'b0) begin
            vtx[0] = b.ax; vtx[1] = b.ay; vtx[2] = b.bx;
            vtx[3] = b.by_coord; vtx[4] = b.cx; vtx[5] = b.cy;
            org_x = b.origin_x; org_y = b.origin_y;
            tex_w = b.tex_width; tex_h = b.tex_height;
            bx_min = vtx[0]; bx_max = vtx[0]; by_min = vtx[1]; by_max = vtx[1];
            for (int i = 1; i < 3; i++) begin
                if (vtx[2*i] < bx_min) bx_min = vtx[2*i];
                if (vtx[2*i] > bx_max) bx_max = vtx[2*i];
                if (vtx[2*i+1] < by_min) by_min = vtx[2*i+1];
                if (vtx[2*i+1] > by_max) by_max = vtx[2*i+1];
            end
            walk_px = bx_min;
            walk_py = by_min;
            walking = (bx_min < bx_max) && (by_min < by_max);
            return;
        end
        r = '0;
        if (!walking) begin
            r.done_res = 1'b1;
            pixel_queue.push_back(r);
            return;
        end
        sx = org_x - walk_px;
        sy = org_y - walk_py;
        on = sx >= 0 && sx <= 4095 && sy >= 0 && sy <= 4095;
        u = ((bx_max - walk_px) * tex_w) / (bx_max - bx_min);
        v = ((by_max - walk_py) * tex_h) / (by_max - by_min);
        texel = u + v * tex_w;
        r.covered = edge_test(walk_px, walk_py);
        r.on_screen = on;
        if (on) begin
            r.screen_x = sx[11:0];
            r.screen_y = sy[11:0];
            r.tile_x = 8'((sx >> TILE_SHIFT) & 255);
            r.tile_y = 8'((sy >> TILE_SHIFT) & 255);
            r.offset_x = 8'(sx & ((1 << TILE_SHIFT) - 1) & 255);
            r.offset_y = 8'(sy & ((1 << TILE_SHIFT) - 1) & 255);
        end
        r.texel_index = texel[20:0];
        // Advance the walk in row order
        walk_px++;
        if (walk_px >= bx_max) begin
            walk_px = bx_min;
            walk_py++;
            if (walk_py >= by_max) begin
                walking = 1'b0;
                r.last = 1'b1;
            end
        end
        pixel_queue.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            vtx = '{default: 0};
            org_x = 0; org_y = 0; tex_w = 1; tex_h = 1;
            bx_min = 0; bx_max = 0; by_min = 0; by_max = 0;
            walk_px = 0; walk_py = 0; walking = 0;
            pixel_queue.delete();
            o_fail_count <= 0;
            o_pixels <= 0;
            o_covered <= 0;
            o_pending <= 0;
        end else begin
            // Compare the output beat against the oldest prediction
            if (o_valid && !i_stall) begin
                if (pixel_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result beat %p", $realtime, o_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pixel_queue.pop_front();
                    if (want !== o_data) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch exp %p got %p", $realtime, want, o_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (!want.done_res) o_pixels <= o_pixels + 1;
                    if (want.covered) o_covered <= o_covered + 1;
                end
            end
            if (i_valid && !o_stall) rasterize_beat(i_data);
            o_pending <= pixel_queue.size();
        end
    end
endmodule

// ===== bench/triangle_bbox_rasterizer_tb.sv =====
// Top of the rasterizer testbench: clock, reset, stimulus and verdict.
// Depends on tbr_pkg, triangle_bbox_rasterizer and its checker.
`timescale 1ns / 1ps

module triangle_bbox_rasterizer_tb;
    import tbr_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_beat   in_data;
    logic       out_valid;
    logic       out_stall;
    t_out_beat  out_data;
    int         fail_count, pending, pixels, covered_cnt;
    int         steps_sent;
    bit         hold_off;

    triangle_bbox_rasterizer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data)
    );

    triangle_bbox_rasterizer_checker CHK (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .i_stall(out_stall), .i_data(in_data),
        .o_valid(out_valid), .o_stall(in_stall), .o_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_pixels(pixels), .o_covered(covered_cnt)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Limit: ~1300 items, stalls included, with wide margin
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver stall pattern, with long hold-offs
    initial begin
        int mode_sel;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) out_stall <= 1'b1;
            else begin
                mode_sel = (steps_sent / 200) % 3;
                if (mode_sel == 0) out_stall <= 1'b0;
                else if (mode_sel == 1) out_stall <= ($urandom_range(0, 3) == 0);
                else out_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    function automatic logic signed [11:0] rand_coord(int spread);
        int c;
        c = $urandom_range(0, 4095);
        if (spread > 0) c = (c % (2 * spread + 1)) - spread;
        return 12'(c);
    endfunction

    // Drive one beat and wait for its acceptance; drop valid only for an idle gap
    task automatic send_beat(t_in_beat b, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (b.mode) steps_sent++;
    endtask

    function automatic t_in_beat load_beat(int x0, int y0, int x1, int y1, int x2, int y2,
                                           int ox, int oy, int tw, int th);
        t_in_beat b;
        b = '0;
        b.mode = 1'b0;
        b.ax = 12'(x0); b.ay = 12'(y0); b.bx = 12'(x1);
        b.by_coord = 12'(y1); b.cx = 12'(x2); b.cy = 12'(y2);
        b.origin_x = 12'(ox); b.origin_y = 12'(oy);
        b.tex_width = 11'(tw); b.tex_height = 11'(th);
        return b;
    endfunction

    function automatic t_in_beat step_beat();
        t_in_beat b;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(t_in_beat)-1:0];
        b.mode = 1'b1;
        return b;
    endfunction

    task automatic walk(int n, int gap_max);
        for (int i = 0; i < n; i++) send_beat(step_beat(), $urandom_range(0, gap_max));
    endtask

    initial begin
        t_in_beat b;
        int burst, n, spread;
        i_rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        hold_off = 0;
        steps_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: step with nothing loaded, small triangles, extremes, empty box
        walk(1, 0);
        send_beat(load_beat(0, 0, 3, 0, 0, 2, 10, 10, 1024, 1024), 0);
        walk(7, 0);
        send_beat(load_beat(-2048, -2048, 2047, 2047, -2048, 2047, 4095, 0, 0, 2047), 0);
        walk(3, 1);
        send_beat(load_beat(2047, 2047, 2046, 2047, 2047, 2045, 2047, 2047, 1, 1), 0);
        walk(3, 0);
        send_beat(load_beat(5, 5, 5, 9, 5, 1, 100, 100, 8, 8), 0);
        walk(1, 0);
        send_beat(load_beat(1, 1, 4, 1, 1, 4, 300, 20, 1024, 3), 0);
        walk(2, 0);
        // Load during a walk restarts at the new box corner
        send_beat(load_beat(-3, 2, 0, -1, 2, 3, 0, 4095, 1500, 0), 0);
        walk(3, 0);

        // Random: mostly well-formed triangle walks, some noise
        while (steps_sent < 1300) begin
            spread = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            b = load_beat(rand_coord(spread), rand_coord(spread), rand_coord(spread),
                          rand_coord(spread), rand_coord(spread), rand_coord(spread),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(1, 1024),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(1, 1024));
            if ($urandom_range(0, 3) == 0) begin
                b.origin_x = 12'($urandom_range(0, 8));
                b.origin_y = 12'($urandom_range(4090, 4095));
            end
            burst = $urandom_range(0, 3);
            send_beat(b, (burst == 0) ? $urandom_range(0, 6) : 0);
            n = $urandom_range(1, 40);
            // Long receiver hold-off while steps keep coming
            if (steps_sent > 600 && steps_sent < 650) begin
                hold_off = 1;
                fork
                    begin
                        repeat (400) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            walk(n, (burst == 0) ? 4 : 0);
        end

        // Drain
        in_valid <= 1'b0;
        n = 0;
        while (pending != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (80) @(posedge i_clk);
        $display("Covered %0d steps, %0d pixels walked, %0d covered.",
                 steps_sent, pixels, covered_cnt);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
